>>> rtl/core/sgdfr_pkg.sv
// Package for the sparse graph depth-first reach block.
// Holds sizes, action codes and sequencer states; no dependencies.
package sgdfr_pkg;

    localparam int NODES   = 64;
    localparam int EDGES   = 1024;
    localparam int NODE_W  = 6;
    localparam int COUNT_W = 7;
    localparam int PTR_W   = 11;
    localparam int PERM_W  = 7;
    localparam int COL_AW  = 7;
    localparam int EDGE_AW = 10;

    typedef enum logic [2:0] {
        ACT_WR_COL   = 3'd0,
        ACT_WR_ROW   = 3'd1,
        ACT_WR_PERM  = 3'd2,
        ACT_CLEAR    = 3'd3,
        ACT_SEARCH   = 3'd4,
        ACT_UNUSED_5 = 3'd5,
        ACT_UNUSED_6 = 3'd6,
        ACT_UNUSED_7 = 3'd7
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PERM,
        ST_LO,
        ST_HI,
        ST_END,
        ST_SCAN,
        ST_CHECK,
        ST_POP,
        ST_RESTORE
    } t_state;

endpackage

>>> rtl/core/sgdfr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sgdfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/sparse_graph_depth_first_reach.sv
// Top level of the sparse graph depth-first reach block.
// Depends on sgdfr_pkg and sgdfr_ram.
//
// Usage: a request is taken when start is high and busy is low. Actions 0..2
// write one entry of the column pointer, row index or permutation table;
// action 3 clears all visited marks and loads the output position from
// node_count; actions 5..7 do nothing.
// Action 4 runs a depth-first search from i_start_node. Each finished node
// is shown on o_node/o_slot/o_last for one cycle with o_valid high; o_last
// marks the start node, which finishes last. A marked start node gives none.
// Opening or reopening a node reads the permutation entry, then two column
// pointers through single-read-port RAMs unless it has no column; a scanned
// edge takes a row index read and a mark check; a done column is found by a
// scan step; a finished node is popped and the parent frame restored and
// reopened. busy stays high for the search. node_count is written through
// i_cfg_we/i_cfg_data; the user must do so only while idle, as the block does
// not enforce it. Reset clears marks, stack depth and control; tables are
// undefined until written. The receiver cannot stall results.
module sparse_graph_depth_first_reach
    import sgdfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           i_action,
    input  logic [10:0]          i_address,
    input  logic signed [11:0]   i_value,
    input  logic [NODE_W-1:0]    i_start_node,
    input  logic                 i_cfg_we,
    input  logic [COUNT_W-1:0]   i_cfg_data,
    output logic                 o_valid,
    output logic [NODE_W-1:0]    o_node,
    output logic [NODE_W-1:0]    o_slot,
    output logic                 o_last
);

    t_state              r_state, n_state;
    logic [NODES-1:0]    r_visited, n_visited;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [COUNT_W-1:0]  r_pos, n_pos;
    logic [COUNT_W-1:0]  r_depth, n_depth;
    logic [NODE_W-1:0]   r_j, n_j;
    logic [NODE_W-1:0]   r_col, n_col;
    logic [PTR_W-1:0]    r_p, n_p;
    logic [PTR_W-1:0]    r_hi, n_hi;
    logic                r_resume, n_resume;
    logic                r_valid, n_valid;
    logic [NODE_W-1:0]   r_node, n_node;
    logic [NODE_W-1:0]   r_slot, n_slot;
    logic                r_last, n_last;

    logic                cs_we, row_we, perm_we, stk_we;
    logic [COL_AW-1:0]   cs_raddr;
    logic [EDGE_AW-1:0]  row_raddr;
    logic [NODE_W-1:0]   perm_raddr, stk_raddr, stk_waddr;
    logic [PTR_W-1:0]    cs_rdata, rs_rdata;
    logic [NODE_W-1:0]   row_rdata, ns_rdata;
    logic [PERM_W-1:0]   perm_rdata;
    logic [COUNT_W-1:0]  depth_m1, depth_m2;
    t_action             act;

    assign act      = t_action'(i_action);
    assign depth_m1 = r_depth - COUNT_W'(1);
    assign depth_m2 = r_depth - COUNT_W'(2);

    sgdfr_ram #(.WIDTH(PTR_W), .DEPTH(NODES + 1)) u_col_ram (
        .i_clk(i_clk), .i_we(cs_we), .i_waddr(i_address[COL_AW-1:0]),
        .i_wdata(i_value[PTR_W-1:0]), .i_raddr(cs_raddr), .o_rdata(cs_rdata)
    );

    sgdfr_ram #(.WIDTH(NODE_W), .DEPTH(EDGES)) u_row_ram (
        .i_clk(i_clk), .i_we(row_we), .i_waddr(i_address[EDGE_AW-1:0]),
        .i_wdata(i_value[NODE_W-1:0]), .i_raddr(row_raddr), .o_rdata(row_rdata)
    );

    sgdfr_ram #(.WIDTH(PERM_W), .DEPTH(NODES)) u_perm_ram (
        .i_clk(i_clk), .i_we(perm_we), .i_waddr(i_address[NODE_W-1:0]),
        .i_wdata(i_value[PERM_W-1:0]), .i_raddr(perm_raddr), .o_rdata(perm_rdata)
    );

    sgdfr_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_node_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr),
        .i_wdata(r_j), .i_raddr(stk_raddr), .o_rdata(ns_rdata)
    );

    sgdfr_ram #(.WIDTH(PTR_W), .DEPTH(NODES)) u_resume_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr),
        .i_wdata(r_p), .i_raddr(stk_raddr), .o_rdata(rs_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_visited <= '0;
            r_count   <= COUNT_W'(NODES);
            r_pos     <= COUNT_W'(NODES);
            r_depth   <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_visited <= n_visited;
            r_count   <= n_count;
            r_pos     <= n_pos;
            r_depth   <= n_depth;
            r_valid   <= n_valid;
        end
        r_j      <= n_j;
        r_col    <= n_col;
        r_p      <= n_p;
        r_hi     <= n_hi;
        r_resume <= n_resume;
        r_node   <= n_node;
        r_slot   <= n_slot;
        r_last   <= n_last;
    end

    always_comb begin
        n_state    = r_state;
        n_visited  = r_visited;
        n_count    = i_cfg_we ? i_cfg_data : r_count;
        n_pos      = r_pos;
        n_depth    = r_depth;
        n_j        = r_j;
        n_col      = r_col;
        n_p        = r_p;
        n_hi       = r_hi;
        n_resume   = r_resume;
        n_valid    = 1'b0;
        n_node     = r_node;
        n_slot     = r_slot;
        n_last     = r_last;
        cs_we      = 1'b0;
        row_we     = 1'b0;
        perm_we    = 1'b0;
        stk_we     = 1'b0;
        stk_waddr  = depth_m1[NODE_W-1:0];
        stk_raddr  = depth_m2[NODE_W-1:0];
        cs_raddr   = {1'b0, r_col} + COL_AW'(1);
        row_raddr  = r_p[EDGE_AW-1:0];
        perm_raddr = r_j;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    unique case (act)
                        ACT_WR_COL:  cs_we   = (i_address < 11'(NODES + 1));
                        ACT_WR_ROW:  row_we  = (i_address < 11'(EDGES));
                        ACT_WR_PERM: perm_we = (i_address < 11'(NODES));
                        ACT_CLEAR: begin
                            n_visited = '0;
                            n_pos     = r_count;
                        end
                        ACT_SEARCH: begin
                            if (!r_visited[i_start_node]) begin
                                n_j      = i_start_node;
                                n_depth  = COUNT_W'(1);
                                n_resume = 1'b0;
                                n_state  = ST_PERM;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_PERM: begin
                n_visited[r_j] = 1'b1;
                n_state        = ST_LO;
            end
            ST_LO: begin
                if (perm_rdata >= PERM_W'(NODES)) begin
                    n_hi = '0;
                    if (!r_resume) begin
                        n_p = '0;
                    end
                    n_state = ST_SCAN;
                end else begin
                    cs_raddr = perm_rdata;
                    n_col    = perm_rdata[NODE_W-1:0];
                    n_state  = ST_HI;
                end
            end
            ST_HI: begin
                if (!r_resume) begin
                    n_p = cs_rdata;
                end
                n_state = ST_END;
            end
            ST_END: begin
                n_hi    = (cs_rdata > PTR_W'(EDGES)) ? PTR_W'(EDGES) : cs_rdata;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                n_state = (r_p < r_hi) ? ST_CHECK : ST_POP;
            end
            ST_CHECK: begin
                priority if (r_visited[row_rdata]) begin
                    n_p     = r_p + PTR_W'(1);
                    n_state = ST_SCAN;
                end else if (r_depth < COUNT_W'(NODES)) begin
                    stk_we   = 1'b1;
                    n_depth  = r_depth + COUNT_W'(1);
                    n_j      = row_rdata;
                    n_resume = 1'b0;
                    n_state  = ST_PERM;
                end else begin
                    n_state = ST_POP;
                end
            end
            ST_POP: begin
                n_valid = 1'b1;
                n_node  = r_j;
                n_pos   = r_pos - COUNT_W'(1);
                n_slot  = n_pos[NODE_W-1:0];
                n_depth = depth_m1;
                n_last  = (r_depth == COUNT_W'(1));
                n_state = n_last ? ST_IDLE : ST_RESTORE;
            end
            ST_RESTORE: begin
                n_j      = ns_rdata;
                n_p      = rs_rdata;
                n_resume = 1'b1;
                n_state  = ST_PERM;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_node  = r_node;
    assign o_slot  = r_slot;
    assign o_last  = r_last;

endmodule
